@@ sv/ils_pkg.sv @@
package ils_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int FUNC_BITS  = 3;
    localparam int POS_BITS   = 4;
    localparam int WIN_BITS   = 32;
    localparam int WOUT_BITS  = 32;
    localparam int CNT_BITS   = 5;
    localparam int STAT_BITS  = 2;

    // widest cell index for the largest supported depth
    localparam int IDX_MAX = 10;

    localparam logic [FUNC_BITS-1:0] FN_READ   = 3'd0;
    localparam logic [FUNC_BITS-1:0] FN_PUSH_F = 3'd1;
    localparam logic [FUNC_BITS-1:0] FN_PUSH_B = 3'd2;
    localparam logic [FUNC_BITS-1:0] FN_POP_F  = 3'd3;
    localparam logic [FUNC_BITS-1:0] FN_POP_B  = 3'd4;
    localparam logic [FUNC_BITS-1:0] FN_INSERT = 3'd5;
    localparam logic [FUNC_BITS-1:0] FN_ERASE  = 3'd6;

    localparam logic [STAT_BITS-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_BADIDX = 2'd3;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [POS_BITS-1:0]  position;
        logic [WIN_BITS-1:0]  word_in;
    } t_request;

    typedef struct packed {
        logic [WOUT_BITS-1:0] word_out;
        logic [CNT_BITS-1:0]  entry_count;
        logic [STAT_BITS-1:0] status;
    } t_result;

    typedef enum logic [1:0] {
        CO_HOLD,
        CO_OPEN,
        CO_CLOSE,
        CO_WRITE
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic [IDX_MAX-1:0]   pos;
    } t_cell_ctrl;

endpackage

@@ sv/ils_cell.sv @@
module ils_cell #(
    parameter int WORD_BITS = ils_pkg::WORD_BITS_DEF,
    parameter int INDEX     = 0
) (
    input  logic                   i_clk,
    input  ils_pkg::t_cell_ctrl    i_ctrl,
    input  logic [WORD_BITS-1:0]   i_word,
    input  logic [WORD_BITS-1:0]   i_prev,
    input  logic [WORD_BITS-1:0]   i_next,
    output logic [WORD_BITS-1:0]   o_word
);

    localparam logic [ils_pkg::IDX_MAX-1:0] MY_IDX = ils_pkg::IDX_MAX'(INDEX);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_ctrl.op)
            ils_pkg::CO_OPEN: begin
                if (MY_IDX > i_ctrl.pos) begin
                    n_word = i_prev;
                end else if (MY_IDX == i_ctrl.pos) begin
                    n_word = i_word;
                end
            end
            ils_pkg::CO_CLOSE: begin
                if (MY_IDX >= i_ctrl.pos) begin
                    n_word = i_next;
                end
            end
            ils_pkg::CO_WRITE: begin
                if (MY_IDX == i_ctrl.pos) begin
                    n_word = i_word;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

@@ sv/indexed_list_store_top.sv @@
// Ordered list of up to DEPTH words held in a row of cells, one word per cell.
// A request is taken whenever i_start is high (o_busy stays low), so one request
// per clock is accepted. Its result appears on o_res with o_valid high in the
// cycle after acceptance and for one cycle only; the receiver cannot stall it.
// Insert and erase move every entry behind the position by one place at once,
// each cell taking its neighbor's word. A rejected request (full, empty or bad
// index) leaves the list and the count untouched.
module indexed_list_store_top #(
    parameter int DEPTH     = ils_pkg::DEPTH_DEF,
    parameter int WORD_BITS = ils_pkg::WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  ils_pkg::t_request i_req,
    output logic              o_valid,
    output ils_pkg::t_result  o_res
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > ils_pkg::POS_BITS) ? CW : ils_pkg::POS_BITS;

    logic [WORD_BITS-1:0] w_word [DEPTH];
    logic [WORD_BITS-1:0] w_in_word;
    logic                 w_accept;
    logic [PW-1:0]        w_pos;
    logic [PW-1:0]        w_cnt;
    logic [IW-1:0]        w_idx;

    ils_pkg::t_cell_ctrl  w_ctrl;
    ils_pkg::t_cell_ctrl  n_ctrl;

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_valid;
    ils_pkg::t_result     r_res;
    ils_pkg::t_result     n_res;

    assign o_busy    = 1'b0;
    assign w_accept  = i_start && !o_busy;
    assign w_in_word = WORD_BITS'(i_req.word_in);
    assign w_pos     = PW'(i_req.position);
    assign w_cnt     = PW'(r_count);
    assign w_idx     = w_pos[IW-1:0];

    always_comb begin
        n_ctrl.op  = ils_pkg::CO_HOLD;
        n_ctrl.pos = '0;
        n_count    = r_count;
        n_res.word_out    = '0;
        n_res.status      = ils_pkg::ST_OK;
        unique case (i_req.func) inside
            ils_pkg::FN_READ: begin
                if (w_pos >= w_cnt) begin
                    n_res.status = ils_pkg::ST_BADIDX;
                end else begin
                    n_res.word_out = ils_pkg::WOUT_BITS'(w_word[w_idx]);
                end
            end
            ils_pkg::FN_PUSH_F, ils_pkg::FN_PUSH_B: begin
                if (r_count >= CW'(DEPTH)) begin
                    n_res.status = ils_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    if (i_req.func == ils_pkg::FN_PUSH_F) begin
                        n_ctrl.op = ils_pkg::CO_OPEN;
                    end else begin
                        n_ctrl.op  = ils_pkg::CO_WRITE;
                        n_ctrl.pos = ils_pkg::IDX_MAX'(r_count[IW-1:0]);
                    end
                end
            end
            ils_pkg::FN_POP_F, ils_pkg::FN_POP_B: begin
                if (r_count == '0) begin
                    n_res.status = ils_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                    if (i_req.func == ils_pkg::FN_POP_F) begin
                        n_ctrl.op = ils_pkg::CO_CLOSE;
                    end
                end
            end
            ils_pkg::FN_INSERT: begin
                if (w_pos >= w_cnt) begin
                    n_res.status = ils_pkg::ST_BADIDX;
                end else if (r_count >= CW'(DEPTH)) begin
                    n_res.status = ils_pkg::ST_FULL;
                end else begin
                    n_count    = r_count + 1'b1;
                    n_ctrl.op  = ils_pkg::CO_OPEN;
                    n_ctrl.pos = ils_pkg::IDX_MAX'(w_idx);
                end
            end
            ils_pkg::FN_ERASE: begin
                if (w_pos >= w_cnt) begin
                    n_res.status = ils_pkg::ST_BADIDX;
                end else begin
                    n_count    = r_count - 1'b1;
                    n_ctrl.op  = ils_pkg::CO_CLOSE;
                    n_ctrl.pos = ils_pkg::IDX_MAX'(w_idx);
                end
            end
            default: begin
                n_res.status = ils_pkg::ST_OK;
            end
        endcase
        n_res.entry_count = ils_pkg::CNT_BITS'(n_count);
    end

    always_comb begin
        w_ctrl = n_ctrl;
        if (!w_accept) begin
            w_ctrl.op = ils_pkg::CO_HOLD;
        end
    end

    // row of storage cells, each linked to its neighbors (an end cell uses its own word)
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [WORD_BITS-1:0] w_prev;
        logic [WORD_BITS-1:0] w_next;
        if (gi == 0) begin : g_first
            assign w_prev = w_word[gi];
        end else begin : g_mid_prev
            assign w_prev = w_word[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_next = w_word[gi];
        end else begin : g_mid_next
            assign w_next = w_word[gi+1];
        end
        ils_cell #(
            .WORD_BITS (WORD_BITS),
            .INDEX     (gi)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_word (w_in_word),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_word (w_word[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_full_at_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.status == ils_pkg::ST_FULL) |-> r_count == CW'(DEPTH))
        else $error("full status with free room");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.status != ils_pkg::ST_OK) |-> r_count == $past(r_count))
        else $error("rejected item changed the count");

    a_step_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
        (r_count == CW'($past(r_count) + 1'b1) || r_count == CW'($past(r_count) - 1'b1)))
        else $error("count moved by more than one");

    a_word_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.word_out != '0) |-> r_res.status == ils_pkg::ST_OK)
        else $error("word returned on rejected item");

endmodule
